### hw/rtl/tppa_pkg.sv
// Shared types and constants for the two-point planar alignment block.
// Used by the datapath units, the top level and the port checker.
`default_nettype none

package tppa_pkg;

    // Field widths
    localparam int COORD_W   = 32;            // coordinate / result width
    localparam int FRAC_W    = 16;            // fractional bits
    localparam int REG_W     = 31;            // configuration register width
    localparam int CFG_IDX_W = 2;             // register index width

    // Internal widths
    localparam int AW     = COORD_W + 1;      // point difference / pair sum
    localparam int PW     = 2 * AW;           // product of two differences
    localparam int ROOT_W = AW;               // integer square root width
    localparam int NUM_W  = PW + FRAC_W;      // divider numerator magnitude
    localparam int Q_W    = COORD_W - 1;      // unsaturated quotient width
    localparam int DW     = PW + Q_W;         // divider compare width
    localparam int MW     = COORD_W + AW;     // rotation times pair sum
    localparam int TW     = MW + 3;           // translation accumulator

    localparam logic signed [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_COINCIDE = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIDAR_HEIGHT = 2'd0,
        CFG_IMU_HEIGHT   = 2'd1,
        CFG_SPACING_TOL  = 2'd2
    } t_cfg_idx;

    localparam logic [REG_W-1:0] RST_LIDAR_HEIGHT = 31'd0;
    localparam logic [REG_W-1:0] RST_IMU_HEIGHT   = 31'd17957;
    localparam logic [REG_W-1:0] RST_SPACING_TOL  = 31'd32768;

    typedef struct packed {
        logic signed [COORD_W-1:0] ref_first_x;
        logic signed [COORD_W-1:0] ref_first_y;
        logic signed [COORD_W-1:0] ref_second_x;
        logic signed [COORD_W-1:0] ref_second_y;
        logic signed [COORD_W-1:0] sensor_first_x;
        logic signed [COORD_W-1:0] sensor_first_y;
        logic signed [COORD_W-1:0] sensor_second_x;
        logic signed [COORD_W-1:0] sensor_second_y;
    } t_in;

    typedef struct packed {
        t_status                   status;
        logic signed [COORD_W-1:0] rot_cos;
        logic signed [COORD_W-1:0] rot_sin;
        logic signed [COORD_W-1:0] offset_x;
        logic signed [COORD_W-1:0] offset_y;
        logic signed [COORD_W-1:0] offset_z;
    } t_out;

    // Data riding alongside the square root units
    typedef struct packed {
        logic signed [PW:0]   dot;
        logic signed [PW:0]   crs;
        logic [PW-1:0]        den;
        logic signed [AW-1:0] rsx;
        logic signed [AW-1:0] rsy;
        logic signed [AW-1:0] ssx;
        logic signed [AW-1:0] ssy;
    } t_side1;

    // Data riding alongside the dividers
    typedef struct packed {
        t_status              status;
        logic                 sat_c;
        logic                 neg_c;
        logic                 sat_s;
        logic                 neg_s;
        logic signed [AW-1:0] rsx;
        logic signed [AW-1:0] rsy;
        logic signed [AW-1:0] ssx;
        logic signed [AW-1:0] ssy;
    } t_side2;

endpackage

`default_nettype wire

### hw/rtl/two_point_planar_alignment.sv
// Two-point planar alignment: stages 1-3, roots, stage 4, dividers, stages 5-7.
// Throughput one transfer per cycle; the whole pipe advances together and
// holds while a finished result is stalled at the output register.
// Synchronous active-low reset clears valid bits and loads the register
// defaults (lidar 0, IMU 0.274, tolerance 0.5). Uses tppa_pkg, tppa_sqrt, tppa_div.
`default_nettype none

module two_point_planar_alignment (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire tppa_pkg::t_in                     i_in,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output tppa_pkg::t_out                         o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [tppa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [tppa_pkg::REG_W-1:0]        i_cfg_data
);

    localparam int CW = tppa_pkg::COORD_W;
    localparam int FW = tppa_pkg::FRAC_W;
    localparam int AW = tppa_pkg::AW;
    localparam int PW = tppa_pkg::PW;
    localparam int RW = tppa_pkg::ROOT_W;
    localparam int NW = tppa_pkg::NUM_W;
    localparam int QW = tppa_pkg::Q_W;
    localparam int DW = tppa_pkg::DW;
    localparam int MW = tppa_pkg::MW;
    localparam int TW = tppa_pkg::TW;
    localparam int N1 = tppa_pkg::ROOT_W;   // sqrt depth
    localparam int N2 = tppa_pkg::Q_W;      // divider depth

    logic adv;

    // Configuration registers
    logic [tppa_pkg::REG_W-1:0] r_lidar, r_imu, r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lidar <= tppa_pkg::RST_LIDAR_HEIGHT;
            r_imu   <= tppa_pkg::RST_IMU_HEIGHT;
            r_tol   <= tppa_pkg::RST_SPACING_TOL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tppa_pkg::CFG_LIDAR_HEIGHT: r_lidar <= i_cfg_data;
                tppa_pkg::CFG_IMU_HEIGHT:   r_imu   <= i_cfg_data;
                tppa_pkg::CFG_SPACING_TOL:  r_tol   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipe advances unless the output holds a result that is stalled
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    // Valid bits
    logic          r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic [N1-1:0] r_vq1;
    logic [N2-1:0] r_vq2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_vq1   <= '0;
            r_v4    <= 1'b0;
            r_vq2   <= '0;
            r_v5    <= 1'b0;
            r_v6    <= 1'b0;
            o_valid <= 1'b0;
        end else if (adv) begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_vq1   <= {r_vq1[N1-2:0], r_v3};
            r_v4    <= r_vq1[N1-1];
            r_vq2   <= {r_vq2[N2-2:0], r_v4};
            r_v5    <= r_vq2[N2-1];
            r_v6    <= r_v5;
            o_valid <= r_v6;
        end
    end

    // Stage 1: spacing vectors and pair sums
    logic signed [AW-1:0] r_ax, r_ay, r_bx, r_by;
    logic signed [AW-1:0] r_rsx1, r_rsy1, r_ssx1, r_ssy1;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ax   <= AW'(i_in.ref_first_x) - AW'(i_in.ref_second_x);
            r_ay   <= AW'(i_in.ref_first_y) - AW'(i_in.ref_second_y);
            r_bx   <= AW'(i_in.sensor_first_x) - AW'(i_in.sensor_second_x);
            r_by   <= AW'(i_in.sensor_first_y) - AW'(i_in.sensor_second_y);
            r_rsx1 <= AW'(i_in.ref_first_x) + AW'(i_in.ref_second_x);
            r_rsy1 <= AW'(i_in.ref_first_y) + AW'(i_in.ref_second_y);
            r_ssx1 <= AW'(i_in.sensor_first_x) + AW'(i_in.sensor_second_x);
            r_ssy1 <= AW'(i_in.sensor_first_y) + AW'(i_in.sensor_second_y);
        end
    end

    // Stage 2: products
    logic signed [PW-1:0] r_axax, r_ayay, r_bxbx, r_byby;
    logic signed [PW-1:0] r_axbx, r_ayby, r_axby, r_aybx;
    logic signed [AW-1:0] r_rsx2, r_rsy2, r_ssx2, r_ssy2;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_axax <= r_ax * r_ax;
            r_ayay <= r_ay * r_ay;
            r_bxbx <= r_bx * r_bx;
            r_byby <= r_by * r_by;
            r_axbx <= r_ax * r_bx;
            r_ayby <= r_ay * r_by;
            r_axby <= r_ax * r_by;
            r_aybx <= r_ay * r_bx;
            r_rsx2 <= r_rsx1;
            r_rsy2 <= r_rsy1;
            r_ssx2 <= r_ssx1;
            r_ssy2 <= r_ssy1;
        end
    end

    // Stage 3: squared spacings, dot and cross products
    logic [PW-1:0]     r_aa;
    tppa_pkg::t_side1  r_s3;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_aa       <= $unsigned(r_axax + r_ayay);
            r_s3.den   <= $unsigned(r_bxbx + r_byby);
            r_s3.dot   <= (PW+1)'(r_axbx) + (PW+1)'(r_ayby);
            r_s3.crs   <= (PW+1)'(r_axby) - (PW+1)'(r_aybx);
            r_s3.rsx   <= r_rsx2;
            r_s3.rsy   <= r_rsy2;
            r_s3.ssx   <= r_ssx2;
            r_s3.ssy   <= r_ssy2;
        end
    end

    // Square roots of both spacings
    logic [RW-1:0] root_a, root_b;

    tppa_sqrt u_sqrt_ref (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_value (r_aa),
        .o_root  (root_a)
    );

    tppa_sqrt u_sqrt_sen (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_value (r_s3.den),
        .o_root  (root_b)
    );

    tppa_pkg::t_side1 r_sl1 [N1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sl1[0] <= r_s3;
            for (int k = 1; k < N1; k++) begin
                r_sl1[k] <= r_sl1[k-1];
            end
        end
    end

    // Stage 4: status, numerator magnitudes, saturation pre-check
    tppa_pkg::t_side1 s1;
    logic [RW-1:0]    diff;
    logic [PW-1:0]    abs_dot, abs_crs;
    logic [NW-1:0]    num_c, num_s;
    logic [DW-1:0]    den_lim;

    assign s1      = r_sl1[N1-1];
    assign diff    = (root_a > root_b) ? (root_a - root_b) : (root_b - root_a);
    assign abs_dot = s1.dot[PW] ? PW'(-s1.dot) : PW'(s1.dot);
    assign abs_crs = s1.crs[PW] ? PW'(-s1.crs) : PW'(s1.crs);
    assign num_c   = {abs_dot, {FW{1'b0}}};
    assign num_s   = {abs_crs, {FW{1'b0}}};
    assign den_lim = {s1.den, {QW{1'b0}}};

    tppa_pkg::t_side2 r_s4;
    logic [NW-1:0]    r_num_c, r_num_s;
    logic [PW-1:0]    r_den4;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (diff > RW'(r_tol)) begin
                r_s4.status <= tppa_pkg::ST_MISMATCH;
            end else if (s1.den == '0) begin
                r_s4.status <= tppa_pkg::ST_COINCIDE;
            end else begin
                r_s4.status <= tppa_pkg::ST_OK;
            end
            r_s4.sat_c <= DW'(num_c) >= den_lim;
            r_s4.sat_s <= DW'(num_s) >= den_lim;
            r_s4.neg_c <= s1.dot[PW];
            r_s4.neg_s <= s1.crs[PW];
            r_s4.rsx   <= s1.rsx;
            r_s4.rsy   <= s1.rsy;
            r_s4.ssx   <= s1.ssx;
            r_s4.ssy   <= s1.ssy;
            r_num_c    <= num_c;
            r_num_s    <= num_s;
            r_den4     <= s1.den;
        end
    end

    // Dividers for the cosine and sine terms
    logic [QW-1:0] quot_c, quot_s;

    tppa_div u_div_cos (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_num  (r_num_c),
        .i_den  (r_den4),
        .o_quot (quot_c)
    );

    tppa_div u_div_sin (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_num  (r_num_s),
        .i_den  (r_den4),
        .o_quot (quot_s)
    );

    tppa_pkg::t_side2 r_sl2 [N2];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sl2[0] <= r_s4;
            for (int k = 1; k < N2; k++) begin
                r_sl2[k] <= r_sl2[k-1];
            end
        end
    end

    // Stage 5: signed, saturated rotation terms
    tppa_pkg::t_side2      s2;
    logic signed [CW-1:0]  qc_ext, qs_ext;
    tppa_pkg::t_side2      r_s5;
    logic signed [CW-1:0]  r_c, r_s;

    assign s2     = r_sl2[N2-1];
    assign qc_ext = $signed({1'b0, quot_c});
    assign qs_ext = $signed({1'b0, quot_s});

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (s2.sat_c) begin
                r_c <= s2.neg_c ? tppa_pkg::SAT_MIN : tppa_pkg::SAT_MAX;
            end else begin
                r_c <= s2.neg_c ? -qc_ext : qc_ext;
            end
            if (s2.sat_s) begin
                r_s <= s2.neg_s ? tppa_pkg::SAT_MIN : tppa_pkg::SAT_MAX;
            end else begin
                r_s <= s2.neg_s ? -qs_ext : qs_ext;
            end
            r_s5 <= s2;
        end
    end

    // Stage 6: rotation applied to the sensor pair sums
    logic signed [MW-1:0]  r_m_cx, r_m_sy, r_m_sx, r_m_cy;
    logic signed [CW-1:0]  r_c6, r_s6;
    tppa_pkg::t_side2      r_s6_side;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m_cx    <= MW'(r_c) * MW'(r_s5.ssx);
            r_m_sy    <= MW'(r_s) * MW'(r_s5.ssy);
            r_m_sx    <= MW'(r_s) * MW'(r_s5.ssx);
            r_m_cy    <= MW'(r_c) * MW'(r_s5.ssy);
            r_c6      <= r_c;
            r_s6      <= r_s;
            r_s6_side <= r_s5;
        end
    end

    // Stage 7: translation sums, halving shift, saturation, output register
    logic signed [TW-1:0]  sum_x, sum_y, sh_x, sh_y;
    logic signed [CW-1:0]  off_x, off_y, off_z;
    logic                  fit_x, fit_y;

    assign sum_x = (TW'(r_s6_side.rsx) <<< FW) - TW'(r_m_cx) - TW'(r_m_sy);
    assign sum_y = (TW'(r_s6_side.rsy) <<< FW) + TW'(r_m_sx) - TW'(r_m_cy);
    assign sh_x  = sum_x >>> (FW + 1);
    assign sh_y  = sum_y >>> (FW + 1);
    assign fit_x = (&sh_x[TW-1:CW-1]) || !(|sh_x[TW-1:CW-1]);
    assign fit_y = (&sh_y[TW-1:CW-1]) || !(|sh_y[TW-1:CW-1]);
    assign off_x = fit_x ? sh_x[CW-1:0]
                         : (sh_x[TW-1] ? tppa_pkg::SAT_MIN : tppa_pkg::SAT_MAX);
    assign off_y = fit_y ? sh_y[CW-1:0]
                         : (sh_y[TW-1] ? tppa_pkg::SAT_MIN : tppa_pkg::SAT_MAX);
    assign off_z = $signed({1'b0, r_lidar}) - $signed({1'b0, r_imu});

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_out.status <= r_s6_side.status;
            if (r_s6_side.status == tppa_pkg::ST_OK) begin
                o_out.rot_cos  <= r_c6;
                o_out.rot_sin  <= r_s6;
                o_out.offset_x <= off_x;
                o_out.offset_y <= off_y;
                o_out.offset_z <= off_z;
            end else begin
                o_out.rot_cos  <= '0;
                o_out.rot_sin  <= '0;
                o_out.offset_x <= '0;
                o_out.offset_y <= '0;
                o_out.offset_z <= '0;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/tppa_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on tppa_pkg for widths.
`default_nettype none

module tppa_sqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [tppa_pkg::PW-1:0]       i_value,
    output logic      [tppa_pkg::ROOT_W-1:0]   o_root
);

    localparam int N  = tppa_pkg::ROOT_W;
    localparam int SW = tppa_pkg::PW + 1;

    logic [SW-1:0] r_x [N];
    logic [SW-1:0] r_r [N];
    logic [SW-1:0] n_x [N];
    logic [SW-1:0] n_r [N];

    // One digit-by-digit step per stage, trial bit walks down by powers of four
    always_comb begin
        logic [SW-1:0] x_in;
        logic [SW-1:0] r_in;
        logic [SW-1:0] bitv;
        logic [SW-1:0] trial;
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                x_in = SW'(i_value);
                r_in = '0;
            end else begin
                x_in = r_x[k-1];
                r_in = r_r[k-1];
            end
            bitv  = SW'(1) << (2 * (N - 1 - k));
            trial = r_in + bitv;
            if (x_in >= trial) begin
                n_x[k] = x_in - trial;
                n_r[k] = (r_in >> 1) + bitv;
            end else begin
                n_x[k] = x_in;
                n_r[k] = r_in >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_x[k] <= n_x[k];
                r_r[k] <= n_r[k];
            end
        end
    end

    assign o_root = r_r[N-1][N-1:0];

endmodule

`default_nettype wire

### hw/rtl/tppa_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Caller guarantees the quotient fits Q_W bits. Depends on tppa_pkg.
`default_nettype none

module tppa_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic [tppa_pkg::NUM_W-1:0]   i_num,
    input  wire logic [tppa_pkg::PW-1:0]      i_den,
    output logic      [tppa_pkg::Q_W-1:0]     o_quot
);

    localparam int M  = tppa_pkg::Q_W;
    localparam int NW = tppa_pkg::NUM_W;
    localparam int DW = tppa_pkg::DW;
    localparam int PW = tppa_pkg::PW;

    logic [NW-1:0] r_rem [M];
    logic [PW-1:0] r_den [M];
    logic [M-1:0]  r_q   [M];
    logic [NW-1:0] n_rem [M];
    logic [M-1:0]  n_q   [M];

    // Stage k tries the divisor shifted to quotient bit M-1-k
    always_comb begin
        logic [NW-1:0] rem_in;
        logic [PW-1:0] den_in;
        logic [M-1:0]  q_in;
        logic [DW-1:0] trial;
        for (int k = 0; k < M; k++) begin
            if (k == 0) begin
                rem_in = i_num;
                den_in = i_den;
                q_in   = '0;
            end else begin
                rem_in = r_rem[k-1];
                den_in = r_den[k-1];
                q_in   = r_q[k-1];
            end
            trial = DW'(den_in) << (M - 1 - k);
            if (DW'(rem_in) >= trial) begin
                n_rem[k] = NW'(DW'(rem_in) - trial);
                n_q[k]   = {q_in[M-2:0], 1'b1};
            end else begin
                n_rem[k] = rem_in;
                n_q[k]   = {q_in[M-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < M; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                if (k == 0) begin
                    r_den[k] <= i_den;
                end else begin
                    r_den[k] <= r_den[k-1];
                end
            end
        end
    end

    assign o_quot = r_q[M-1];

endmodule

`default_nettype wire

### hw/rtl/tppa_checker.sv
// Port-level checks for the two-point planar alignment block, bound to the top.
// Depends on tppa_pkg and two_point_planar_alignment.
`default_nettype none

module tppa_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            o_stall,
    input wire logic            o_valid,
    input wire logic            i_stall,
    input wire tppa_pkg::t_out  o_out
);

    // A held result stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out))
        else $error("output transfer changed while stalled");

    // Input back-pressure only comes from a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output back-pressure");

    // Failed items carry all-zero values
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.status != tppa_pkg::ST_OK |->
            o_out.rot_cos == '0 && o_out.rot_sin == '0 && o_out.offset_x == '0 &&
            o_out.offset_y == '0 && o_out.offset_z == '0)
        else $error("nonzero values on a failed result");

    // Reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind two_point_planar_alignment tppa_checker u_tppa_checker (.*);

`default_nettype wire

### sim/tb_two_point_planar_alignment.sv
// Self-checking testbench for two_point_planar_alignment: random and directed
// point pairs, predicted in a scoreboard class. Depends on tppa_pkg and the RTL.
`timescale 1ns / 1ps

module tb_two_point_planar_alignment;

    // Scoreboard: predicts the pose for each accepted transfer, checks results
    class pose_board;
        tppa_pkg::t_out pose_q[$];
        logic [tppa_pkg::REG_W-1:0] lidar_h = tppa_pkg::RST_LIDAR_HEIGHT;
        logic [tppa_pkg::REG_W-1:0] imu_h   = tppa_pkg::RST_IMU_HEIGHT;
        logic [tppa_pkg::REG_W-1:0] tol     = tppa_pkg::RST_SPACING_TOL;
        int     errors = 0;

        function void set_reg(tppa_pkg::t_cfg_idx idx, logic [tppa_pkg::REG_W-1:0] val);
            case (idx)
                tppa_pkg::CFG_LIDAR_HEIGHT: lidar_h = val;
                tppa_pkg::CFG_IMU_HEIGHT:   imu_h = val;
                tppa_pkg::CFG_SPACING_TOL:  tol = val;
                default: ;
            endcase
        endfunction

        function logic [63:0] root(logic [127:0] v);
            logic [63:0] r;
            logic [63:0] t;
            logic [127:0] sq;
            r = '0;
            for (int i = 63; i >= 0; i--) begin
                t = r | (64'd1 << i);
                sq = {64'd0, t} * {64'd0, t};
                if (sq <= v) r = t;
            end
            return r;
        endfunction

        function logic signed [tppa_pkg::COORD_W-1:0] clamp(logic signed [127:0] w);
            if (w > 128'sd2147483647) return tppa_pkg::SAT_MAX;
            if (w < -128'sd2147483648) return tppa_pkg::SAT_MIN;
            return w[tppa_pkg::COORD_W-1:0];
        endfunction

        function void note(tppa_pkg::t_in x);
            logic signed [127:0] ax, ay, bx, by, den, dot, crs, cw, sw, sx, sy;
            logic signed [127:0] r0x, r0y, r1x, r1y, s0x, s0y, s1x, s1y;
            logic [63:0] na, nb, diff;
            tppa_pkg::t_out e;
            r0x = x.ref_first_x;     r0y = x.ref_first_y;
            r1x = x.ref_second_x;    r1y = x.ref_second_y;
            s0x = x.sensor_first_x;  s0y = x.sensor_first_y;
            s1x = x.sensor_second_x; s1y = x.sensor_second_y;
            ax = r0x - r1x; ay = r0y - r1y; bx = s0x - s1x; by = s0y - s1y;
            den = bx * bx + by * by;
            na = root(ax * ax + ay * ay);
            nb = root(den);
            diff = (na > nb) ? na - nb : nb - na;
            e = '0;
            if (diff > {33'd0, tol}) begin
                e.status = tppa_pkg::ST_MISMATCH;
            end else if (den == 0) begin
                e.status = tppa_pkg::ST_COINCIDE;
            end else begin
                dot = ax * bx + ay * by;
                crs = ax * by - ay * bx;
                // signed division truncates toward zero
                e.rot_cos = clamp((dot <<< tppa_pkg::FRAC_W) / den);
                e.rot_sin = clamp((crs <<< tppa_pkg::FRAC_W) / den);
                cw = e.rot_cos;
                sw = e.rot_sin;
                sx = ((r0x + r1x) <<< tppa_pkg::FRAC_W) - (cw * s0x + sw * s0y)
                     - (cw * s1x + sw * s1y);
                sy = ((r0y + r1y) <<< tppa_pkg::FRAC_W) + (sw * s0x - cw * s0y)
                     + (sw * s1x - cw * s1y);
                e.offset_x = clamp(sx >>> (tppa_pkg::FRAC_W + 1));
                e.offset_y = clamp(sy >>> (tppa_pkg::FRAC_W + 1));
                e.offset_z = clamp($signed({97'd0, lidar_h}) - $signed({97'd0, imu_h}));
                e.status = tppa_pkg::ST_OK;
            end
            pose_q = {pose_q, e};
        endfunction

        function void check(tppa_pkg::t_out got);
            tppa_pkg::t_out e;
            if (pose_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = pose_q.pop_front();
            if (got.status !== e.status) begin
                $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
                errors++;
            end
            if (got.rot_cos !== e.rot_cos) begin
                $display("%0t: rot_cos exp %h got %h", $time, e.rot_cos, got.rot_cos);
                errors++;
            end
            if (got.rot_sin !== e.rot_sin) begin
                $display("%0t: rot_sin exp %h got %h", $time, e.rot_sin, got.rot_sin);
                errors++;
            end
            if (got.offset_x !== e.offset_x) begin
                $display("%0t: offset_x exp %h got %h", $time, e.offset_x, got.offset_x);
                errors++;
            end
            if (got.offset_y !== e.offset_y) begin
                $display("%0t: offset_y exp %h got %h", $time, e.offset_y, got.offset_y);
                errors++;
            end
            if (got.offset_z !== e.offset_z) begin
                $display("%0t: offset_z exp %h got %h", $time, e.offset_z, got.offset_z);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    tppa_pkg::t_in    i_in = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    tppa_pkg::t_out   o_out;
    logic             i_cfg_we = 1'b0;
    logic [tppa_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [tppa_pkg::REG_W-1:0]     i_cfg_data = '0;

    pose_board board = new();
    int tx_idle_pct = 25;
    int rx_idle_pct = 80;
    int unsigned cycles = 0;

    two_point_planar_alignment u_top (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 600000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: random stall, checks each transfer out
    initial begin
        forever begin
            i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) board.check(o_out);
        end
    end

    task automatic send(tppa_pkg::t_in x);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in <= x;
        do @(posedge i_clk); while (o_stall);
        board.note(x);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.pose_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(tppa_pkg::t_cfg_idx idx, logic [tppa_pkg::REG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        board.set_reg(idx, val);
    endtask

    function automatic logic signed [31:0] rnd(int unsigned m);
        return $signed($urandom_range(0, 2 * m)) - $signed(m);
    endfunction

    // Reference pair = sensor pair turned by k quarter turns, then shifted
    function automatic tppa_pkg::t_in congruent(int unsigned m, int unsigned k);
        tppa_pkg::t_in x;
        logic signed [31:0] tx, ty;
        x = '0;
        x.sensor_first_x = rnd(m);  x.sensor_first_y = rnd(m);
        x.sensor_second_x = rnd(m); x.sensor_second_y = rnd(m);
        tx = rnd(m); ty = rnd(m);
        case (k)
            0: begin
                x.ref_first_x = x.sensor_first_x + tx;  x.ref_first_y = x.sensor_first_y + ty;
                x.ref_second_x = x.sensor_second_x + tx; x.ref_second_y = x.sensor_second_y + ty;
            end
            1: begin
                x.ref_first_x = -x.sensor_first_y + tx;  x.ref_first_y = x.sensor_first_x + ty;
                x.ref_second_x = -x.sensor_second_y + tx; x.ref_second_y = x.sensor_second_x + ty;
            end
            2: begin
                x.ref_first_x = -x.sensor_first_x + tx;  x.ref_first_y = -x.sensor_first_y + ty;
                x.ref_second_x = -x.sensor_second_x + tx; x.ref_second_y = -x.sensor_second_y + ty;
            end
            default: begin
                x.ref_first_x = x.sensor_first_y + tx;  x.ref_first_y = -x.sensor_first_x + ty;
                x.ref_second_x = x.sensor_second_y + tx; x.ref_second_y = -x.sensor_second_x + ty;
            end
        endcase
        return x;
    endfunction

    function automatic tppa_pkg::t_in random_item();
        tppa_pkg::t_in x;
        int unsigned sel;
        int unsigned m;
        sel = $urandom_range(0, 9);
        m = (sel < 3) ? $urandom_range(1, 1 << 20) : $urandom_range(1, 1 << 29);
        if (sel <= 5) begin
            x = congruent(m, $urandom_range(0, 3));
            // small jitter keeps some near the tolerance edge
            if ($urandom_range(0, 3) == 0) x.ref_first_x += rnd(1 << 16);
        end else if (sel == 6) begin
            x = {$urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
        end else if (sel == 7) begin
            x = congruent(m, $urandom_range(0, 3));
            x.sensor_second_x = x.sensor_first_x;
            x.sensor_second_y = x.sensor_first_y;
            x.ref_second_x = x.ref_first_x + rnd(1 << 15);
            x.ref_second_y = x.ref_first_y;
        end else begin
            // large reference spacing against a tiny sensor spacing
            x = congruent(m, 0);
            x.sensor_second_x = x.sensor_first_x + rnd(4);
            x.sensor_second_y = x.sensor_first_y + 1;
        end
        return x;
    endfunction

    initial begin
        tppa_pkg::t_in x;
        logic [31:0] rv;
        logic [tppa_pkg::REG_W-1:0] lh [6] = '{31'h7FFFFFFF, 31'd0, 31'd131072,
                                               31'd0, 31'h7FFFFFFF, 31'd65536};
        logic [tppa_pkg::REG_W-1:0] ih [6] = '{31'd0, 31'h7FFFFFFF, 31'd17957,
                                               31'd0, 31'h7FFFFFFF, 31'd3};
        logic [tppa_pkg::REG_W-1:0] th [6] = '{31'h7FFFFFFF, 31'd0, 31'd65536,
                                               31'h7FFFFFFF, 31'd1, 31'd32768};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, coincident points, mismatch, quarter turns
        x = {8{32'sh7FFFFFFF}};                                   send(x);
        x = {8{32'sh80000000}};                                   send(x);
        x = '0;                                                   send(x);
        x = {32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
             32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF};
        send(x);
        x = {32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
             32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF};
        send(x);
        x = '0; x.ref_first_x = 32'sd65536; send(x);
        x = '0; x.ref_first_x = 32'sd10 << 16; x.sensor_first_x = 32'sd65536; send(x);
        for (int k = 0; k < 4; k++) begin
            send(congruent(1 << 18, k));
            send(congruent(1 << 29, k));
        end
        x = congruent(1 << 18, 0);
        x.ref_first_x += 32'sd32768; send(x);
        x = congruent(1 << 18, 0);
        x.ref_first_x += 32'sd32769; send(x);

        // hold off until every result is back
        drain();

        for (int p = 0; p < 6; p++) begin
            tx_idle_pct = (p < 2) ? 25 : (p < 4) ? 80 : 0;
            rx_idle_pct = (p < 2) ? 80 : (p < 4) ? 25 : 0;
            rv = $urandom;
            write_reg(tppa_pkg::CFG_LIDAR_HEIGHT,
                      (p == 5) ? rv[tppa_pkg::REG_W-1:0] : lh[p]);
            write_reg(tppa_pkg::CFG_IMU_HEIGHT, ih[p]);
            write_reg(tppa_pkg::CFG_SPACING_TOL, th[p]);
            i_cfg_we <= 1'b0;
            repeat (200) send(random_item());
            drain();
        end

        if (board.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### two_point_planar_alignment.f
hw/rtl/tppa_pkg.sv
hw/rtl/tppa_sqrt.sv
hw/rtl/tppa_div.sv
hw/rtl/two_point_planar_alignment.sv
hw/rtl/tppa_checker.sv
sim/tb_two_point_planar_alignment.sv
